/* hw/rtl/psm_pkg.sv */
// Shared types, defaults and lane helpers for the paged subword memory.
package psm_pkg;

    localparam int DEF_PAGE_OFFSET_BITS = 10;
    localparam int DEF_PAGE_INDEX_BITS  = 4;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [1:0] {
        SZ_BYTE  = 2'd0,
        SZ_HALF  = 2'd1,
        SZ_WORD  = 2'd2,
        SZ_DWORD = 2'd3
    } t_size;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ0,
        ST_READ1,
        ST_CLEAR,
        ST_WRITE0,
        ST_WRITE1,
        ST_FIN
    } t_state;

    localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;
    localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;
    localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF;

    // Address low bits must be zero for the access size.
    function automatic logic is_misaligned(input t_size size, input logic [2:0] addr_lo);
        logic mis;
        case (size)
            SZ_BYTE:  mis = 1'b0;
            SZ_HALF:  mis = addr_lo[0];
            SZ_WORD:  mis = (addr_lo[1:0] != 2'b00);
            SZ_DWORD: mis = (addr_lo != 3'b000);
            default:  mis = 1'b0;
        endcase
        return mis;
    endfunction

    function automatic logic [31:0] size_mask(input t_size size);
        logic [31:0] m;
        case (size)
            SZ_BYTE: m = BYTE_MASK;
            SZ_HALF: m = HALF_MASK;
            default: m = WORD_MASK;
        endcase
        return m;
    endfunction

    // Little-endian lane select, zero-extended to 64 bits.
    function automatic logic [63:0] lane_extract(input logic [31:0] w, input t_size size,
                                                 input logic [1:0] lane);
        logic [4:0]  sh;
        logic [31:0] v;
        sh = {lane, 3'b000};
        v  = (w >> sh) & size_mask(size);
        return {32'h0, v};
    endfunction

    // Merge store data into the addressed lanes of an old word.
    function automatic logic [31:0] lane_merge(input logic [31:0] old, input logic [31:0] data,
                                               input t_size size, input logic [1:0] lane);
        logic [4:0]  sh;
        logic [31:0] m;
        sh = {lane, 3'b000};
        m  = size_mask(size) << sh;
        return (old & ~m) | ((data & size_mask(size)) << sh);
    endfunction

endpackage

/* hw/rtl/psm_ram.sv */
// Single-port-write, single-port-read word store with registered read data.
module psm_ram #(
    parameter int ADDR_BITS = psm_pkg::DEF_PAGE_OFFSET_BITS + psm_pkg::DEF_PAGE_INDEX_BITS - 2
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [31:0]          i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [31:0]          o_rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [31:0] r_mem [0:DEPTH-1];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/paged_subword_memory_unit.sv */
// Top level: request sequencer, page flags and result register around the word store.
//
//  channel | dir | tdata                                  | tuser
//  s       | in  | [31:0] byte_address, [95:32] store_value | [0] req_type, [2:1] access_size
//  m       | out | [63:0] load_value                      | [0] misaligned
//
// One store word per cycle. Misaligned, a read of an unmapped page and a mapped word write finish
// in IDLE; a byte/half/word read in READ0, a byte/half write (read-modify-write) in WRITE0, a
// doubleword write in WRITE1, a doubleword read in READ0 then READ1. A first write
// to a page zeroes its 2**(PAGE_OFFSET_BITS-2) words in CLEAR. Reset clears the state, the page
// flags and the output valid flag. A finished result sits in the output register while a new word
// is taken; the sequencer holds the next result until the register is free.
module paged_subword_memory_unit #(
    parameter int PAGE_OFFSET_BITS = psm_pkg::DEF_PAGE_OFFSET_BITS,
    parameter int PAGE_INDEX_BITS  = psm_pkg::DEF_PAGE_INDEX_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // byte_address, store_value
    input  logic [2:0]  i_s_tuser,   // req_type, access_size
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // load_value
    output logic [0:0]  o_m_tuser    // misaligned
);

    localparam int ADDR_BITS  = PAGE_OFFSET_BITS + PAGE_INDEX_BITS - 2;
    localparam int CLR_BITS   = PAGE_OFFSET_BITS - 2;
    localparam int PAGE_COUNT = 1 << PAGE_INDEX_BITS;

    psm_pkg::t_state r_state, n_state;
    logic [PAGE_COUNT-1:0] r_page_valid, n_page_valid;
    logic [CLR_BITS-1:0]   r_clr, n_clr;
    psm_pkg::t_size        r_size, n_size;
    logic [ADDR_BITS-1:0]  r_ramaddr, n_ramaddr;
    logic [1:0]            r_lane, n_lane;
    logic [63:0]           r_data, n_data;
    logic                  r_fresh, n_fresh;
    logic [63:0]           r_res_load, n_res_load;
    logic                  r_res_mis, n_res_mis;
    logic                  r_out_valid, n_out_valid;
    logic [63:0]           r_out_load, n_out_load;
    logic                  r_out_mis, n_out_mis;

    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr, ram_raddr;
    logic [31:0]           ram_wdata, ram_rdata;

    logic                  in_type;
    psm_pkg::t_size        in_size;
    logic [31:0]           in_addr;
    logic [ADDR_BITS-1:0]  in_ramaddr;
    logic [PAGE_INDEX_BITS-1:0] in_page;
    logic                  out_free;
    logic                  fin;
    logic [63:0]           fin_load;
    logic                  fin_mis;

    assign in_type    = i_s_tuser[0];
    assign in_size    = psm_pkg::t_size'(i_s_tuser[2:1]);
    assign in_addr    = i_s_tdata[31:0];
    assign in_page    = in_addr[PAGE_OFFSET_BITS +: PAGE_INDEX_BITS];
    assign in_ramaddr = {in_page, in_addr[PAGE_OFFSET_BITS-1:2]};
    assign out_free   = !r_out_valid || i_m_tready;

    assign o_s_tready = (r_state == psm_pkg::ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_load;
    assign o_m_tuser  = r_out_mis;

    psm_ram #(
        .ADDR_BITS(ADDR_BITS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_page_valid = r_page_valid;
        n_clr        = r_clr;
        n_size       = r_size;
        n_ramaddr    = r_ramaddr;
        n_lane       = r_lane;
        n_data       = r_data;
        n_fresh      = r_fresh;
        n_res_load   = r_res_load;
        n_res_mis    = r_res_mis;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_load   = r_out_load;
        n_out_mis    = r_out_mis;
        ram_we       = 1'b0;
        ram_waddr    = r_ramaddr;
        ram_wdata    = 32'h0;
        ram_raddr    = r_ramaddr;
        fin          = 1'b0;
        fin_load     = 64'h0;
        fin_mis      = 1'b0;

        case (r_state)
            psm_pkg::ST_IDLE: begin
                ram_raddr = in_ramaddr;
                if (i_s_tvalid) begin
                    n_size    = in_size;
                    n_ramaddr = in_ramaddr;
                    n_lane    = in_addr[1:0];
                    n_data    = i_s_tdata[95:32];
                    n_fresh   = 1'b0;
                    if (psm_pkg::is_misaligned(in_size, in_addr[2:0])) begin
                        fin     = 1'b1;
                        fin_mis = 1'b1;
                    end else if (in_type == psm_pkg::REQ_READ) begin
                        if (r_page_valid[in_page]) begin
                            n_state = psm_pkg::ST_READ0;
                        end else begin
                            fin = 1'b1;
                        end
                    end else if (!r_page_valid[in_page]) begin
                        n_fresh = 1'b1;
                        n_clr   = '0;
                        n_state = psm_pkg::ST_CLEAR;
                    end else if (in_size == psm_pkg::SZ_WORD || in_size == psm_pkg::SZ_DWORD) begin
                        ram_we    = 1'b1;
                        ram_waddr = in_ramaddr;
                        ram_wdata = i_s_tdata[63:32];
                        if (in_size == psm_pkg::SZ_DWORD) begin
                            n_state = psm_pkg::ST_WRITE1;
                        end else begin
                            fin = 1'b1;
                        end
                    end else begin
                        n_state = psm_pkg::ST_WRITE0;
                    end
                end
            end
            psm_pkg::ST_READ0: begin
                ram_raddr = {r_ramaddr[ADDR_BITS-1:1], 1'b1};
                if (r_size == psm_pkg::SZ_DWORD) begin
                    n_res_load = {32'h0, ram_rdata};
                    n_state    = psm_pkg::ST_READ1;
                end else begin
                    fin      = 1'b1;
                    fin_load = psm_pkg::lane_extract(ram_rdata, r_size, r_lane);
                end
            end
            psm_pkg::ST_READ1: begin
                fin      = 1'b1;
                fin_load = {ram_rdata, r_res_load[31:0]};
            end
            psm_pkg::ST_CLEAR: begin
                // zero the page one word a cycle, then mark it mapped
                ram_we    = 1'b1;
                ram_waddr = {r_ramaddr[ADDR_BITS-1 -: PAGE_INDEX_BITS], r_clr};
                n_clr     = r_clr + 1'b1;
                if (&r_clr) begin
                    n_page_valid[r_ramaddr[ADDR_BITS-1 -: PAGE_INDEX_BITS]] = 1'b1;
                    n_state = psm_pkg::ST_WRITE0;
                end
            end
            psm_pkg::ST_WRITE0: begin
                ram_we    = 1'b1;
                ram_waddr = r_ramaddr;
                ram_wdata = psm_pkg::lane_merge(r_fresh ? 32'h0 : ram_rdata, r_data[31:0],
                                                r_size, r_lane);
                if (r_size == psm_pkg::SZ_DWORD) begin
                    n_state = psm_pkg::ST_WRITE1;
                end else begin
                    fin = 1'b1;
                end
            end
            psm_pkg::ST_WRITE1: begin
                ram_we    = 1'b1;
                ram_waddr = {r_ramaddr[ADDR_BITS-1:1], 1'b1};
                ram_wdata = r_data[63:32];
                fin       = 1'b1;
            end
            psm_pkg::ST_FIN: begin
                fin      = 1'b1;
                fin_load = r_res_load;
                fin_mis  = r_res_mis;
            end
            default: begin
                n_state = psm_pkg::ST_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_load  = fin_load;
                n_out_mis   = fin_mis;
                n_state     = psm_pkg::ST_IDLE;
            end else begin
                n_res_load = fin_load;
                n_res_mis  = fin_mis;
                n_state    = psm_pkg::ST_FIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= psm_pkg::ST_IDLE;
            r_page_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_page_valid <= n_page_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clr      <= n_clr;
        r_size     <= n_size;
        r_ramaddr  <= n_ramaddr;
        r_lane     <= n_lane;
        r_data     <= n_data;
        r_fresh    <= n_fresh;
        r_res_load <= n_res_load;
        r_res_mis  <= n_res_mis;
        r_out_load <= n_out_load;
        r_out_mis  <= n_out_mis;
    end

    a_clear_writes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psm_pkg::ST_CLEAR) |-> (ram_we && ram_wdata == 32'h0))
        else $error("clearing pass must write zero words");

    a_page_mapped_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psm_pkg::ST_CLEAR && (&r_clr)) |=>
        (r_page_valid[r_ramaddr[ADDR_BITS-1 -: PAGE_INDEX_BITS]] &&
         r_state == psm_pkg::ST_WRITE0))
        else $error("page not mapped after clearing pass");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psm_pkg::ST_READ0 || r_state == psm_pkg::ST_READ1 ||
         r_state == psm_pkg::ST_FIN) |-> !ram_we)
        else $error("store written during a read or result hold");

    a_misaligned_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == 64'h0))
        else $error("misaligned result carries data");

    a_fin_waits_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psm_pkg::ST_FIN) |-> r_out_valid)
        else $error("result held back while output register empty");

endmodule

/* tb/paged_subword_memory_unit_test.sv */
// Self-checking testbench for the paged subword memory unit, with a word-level memory predictor.
`timescale 1ns / 100ps

module paged_subword_memory_unit_test;

    localparam int OFF_BITS       = psm_pkg::DEF_PAGE_OFFSET_BITS;
    localparam int IDX_BITS       = psm_pkg::DEF_PAGE_INDEX_BITS;
    localparam int WORDS_PER_PAGE = 1 << (OFF_BITS - 2);
    localparam int PAGES          = 1 << IDX_BITS;
    localparam logic [31:0] USED_ADDR_MASK = 32'((64'd1 << (OFF_BITS + IDX_BITS)) - 1);
    localparam int LIMIT_CYCLES   = 400000;
    localparam int RANDOM_PER_PHASE = 235;
    localparam int POOL_DEPTH     = 48;

    typedef struct packed {
        logic [63:0] load_value;
        logic        misaligned;
    } t_mem_result;

    class mem_scoreboard;
        logic [31:0]  words [WORDS_PER_PAGE * PAGES];
        bit           mapped [PAGES];
        t_mem_result  pending_q [$];
        int           errors;

        function new();
            errors = 0;
            foreach (mapped[i]) mapped[i] = 1'b0;
        endfunction

        function int page_of(logic [31:0] a);
            return int'((a >> OFF_BITS) & (PAGES - 1));
        endfunction

        function int slot_of(logic [31:0] a);
            return page_of(a) * WORDS_PER_PAGE + int'((a & ((1 << OFF_BITS) - 1)) >> 2);
        endfunction

        function logic [31:0] fetch_word(logic [31:0] a);
            if (!mapped[page_of(a)]) return 32'h0;
            return words[slot_of(a)];
        endfunction

        // First write to a page zeroes the lot before merging
        function void put_word(logic [31:0] a, logic [31:0] v);
            int p;
            p = page_of(a);
            if (!mapped[p]) begin
                mapped[p] = 1'b1;
                for (int i = 0; i < WORDS_PER_PAGE; i++) words[p * WORDS_PER_PAGE + i] = 32'h0;
            end
            words[slot_of(a)] = v;
        endfunction

        function void note_request(logic wr, psm_pkg::t_size sz, logic [31:0] a,
                                   logic [63:0] d);
            t_mem_result r;
            logic [31:0] base, w, m;
            logic [2:0]  align;
            int          sh;
            r     = '0;
            align = 3'((1 << sz) - 1);
            if ((a[2:0] & align) != 3'b000) begin
                r.misaligned = 1'b1;
            end else begin
                base = {a[31:2], 2'b00};
                sh   = int'(a[1:0]) * 8;
                if (wr == psm_pkg::REQ_READ) begin
                    w = fetch_word(base);
                    case (sz)
                        psm_pkg::SZ_BYTE: r.load_value = {32'h0, (w >> sh) & 32'h0000_00FF};
                        psm_pkg::SZ_HALF: r.load_value = {32'h0, (w >> sh) & 32'h0000_FFFF};
                        psm_pkg::SZ_WORD: r.load_value = {32'h0, w};
                        default: r.load_value = {fetch_word(base + 32'd4), w};
                    endcase
                end else begin
                    case (sz)
                        psm_pkg::SZ_BYTE, psm_pkg::SZ_HALF: begin
                            m = (sz == psm_pkg::SZ_BYTE) ? 32'h0000_00FF : 32'h0000_FFFF;
                            w = fetch_word(base);
                            w = (w & ~(m << sh)) | ((d[31:0] & m) << sh);
                            put_word(base, w);
                        end
                        psm_pkg::SZ_WORD: put_word(base, d[31:0]);
                        default: begin
                            put_word(base, d[31:0]);
                            put_word(base + 32'd4, d[63:32]);
                        end
                    endcase
                end
            end
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [63:0] load, logic mis);
            t_mem_result e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: load_value %h misaligned %b", load, mis);
                return;
            end
            e = pending_q.pop_front();
            if (load !== e.load_value || mis !== e.misaligned) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: load_value exp %h got %h, misaligned exp %b got %b",
                             e.load_value, load, e.misaligned, mis);
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [95:0] i_s_tdata  = '0;   // byte_address, store_value
    logic [2:0]  i_s_tuser  = '0;   // req_type, access_size
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;         // load_value
    logic [0:0]  o_m_tuser;         // misaligned

    mem_scoreboard sb;
    logic [31:0]   addr_pool [$];
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            cycles         = 0;

    paged_subword_memory_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("paged_subword_memory_unit test failed");
            $finish;
        end
    end

    // Result side: check on handshake, then pick next tready
    always @(posedge i_clk) begin
        if (o_m_tvalid === 1'b1 && i_m_tready === 1'b1)
            sb.check_result(o_m_tdata, o_m_tuser[0]);
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Called just after an edge; returns just after the edge that took the word
    task automatic issue(input logic wr, input psm_pkg::t_size sz, input logic [31:0] a,
                         input logic [63:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {d, a};
        i_s_tuser  <= {sz, wr};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sb.note_request(wr, sz, a, d);
    endtask

    // Mostly revisits written locations (with aliasing upper bits) so reads hit live data
    task automatic random_request();
        logic           wr;
        psm_pkg::t_size sz;
        logic [31:0]    a;
        logic [63:0]    d;
        wr = ($urandom_range(99) < 45) ? psm_pkg::REQ_WRITE : psm_pkg::REQ_READ;
        sz = psm_pkg::t_size'($urandom_range(3));
        d  = {$urandom, $urandom};
        if (addr_pool.size() > 0 && $urandom_range(99) < 65) begin
            a = addr_pool[$urandom_range(addr_pool.size() - 1)] | 32'($urandom_range(7));
            if ($urandom_range(1) == 1)
                a = (a & USED_ADDR_MASK) | ($urandom & ~USED_ADDR_MASK);
        end else begin
            a = $urandom;
        end
        if ($urandom_range(99) < 88) a = a & ~32'((1 << sz) - 1);
        if (wr == psm_pkg::REQ_WRITE) begin
            addr_pool.push_back(a & ~32'h7);
            if (addr_pool.size() > POOL_DEPTH) void'(addr_pool.pop_front());
        end
        issue(wr, sz, a, d);
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unmapped pages read as zero
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_WORD,  32'h0000_0000, 64'h0);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_DWORD, 32'h0000_0408, 64'h0);
        // first touch of page 0 by a byte write, then lane merges
        issue(psm_pkg::REQ_WRITE, psm_pkg::SZ_BYTE,  32'h0000_0003, 64'hFFFF_FFFF_FFFF_FFA5);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_WORD,  32'h0000_0000, 64'h0);
        issue(psm_pkg::REQ_WRITE, psm_pkg::SZ_HALF,  32'h0000_0002, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(psm_pkg::REQ_WRITE, psm_pkg::SZ_HALF,  32'h0000_0000, 64'h0000_0000_0000_1234);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_DWORD, 32'h0000_0000, 64'h0);
        issue(psm_pkg::REQ_WRITE, psm_pkg::SZ_WORD,  32'h0000_0004, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_DWORD, 32'h0000_0000, 64'h0);
        issue(psm_pkg::REQ_WRITE, psm_pkg::SZ_DWORD, 32'h0000_03F8, 64'h0);
        // top of the address space, and its alias through the ignored upper bits
        issue(psm_pkg::REQ_WRITE, psm_pkg::SZ_DWORD, 32'hFFFF_FFF8, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_BYTE,  32'hFFFF_FFFF, 64'h0);
        issue(psm_pkg::REQ_WRITE, psm_pkg::SZ_BYTE,  32'hFFFF_FFFF, 64'h0000_0000_0000_005A);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_DWORD, 32'h0000_3FF8, 64'h0);
        // misaligned requests change nothing: page 2 stays unmapped until the byte write below
        issue(psm_pkg::REQ_WRITE, psm_pkg::SZ_HALF,  32'h0000_0801, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_WORD,  32'h0000_0800, 64'h0);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_WORD,  32'h0000_0006, 64'h0);
        issue(psm_pkg::REQ_WRITE, psm_pkg::SZ_WORD,  32'h0000_0002, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_DWORD, 32'h0000_0004, 64'h0);
        issue(psm_pkg::REQ_WRITE, psm_pkg::SZ_DWORD, 32'h0000_000C, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_DWORD, 32'h0000_0008, 64'h0);
        issue(psm_pkg::REQ_WRITE, psm_pkg::SZ_BYTE,  32'h0000_0805, 64'h0000_0000_0000_00C3);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_HALF,  32'h0000_0804, 64'h0);
        issue(psm_pkg::REQ_READ,  psm_pkg::SZ_BYTE,  32'h0000_0806, 64'h0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            repeat (RANDOM_PER_PHASE) random_request();
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("paged_subword_memory_unit test passed");
        end else begin
            $display("paged_subword_memory_unit test failed");
        end
        $finish;
    end

endmodule
